>>> hdl/mm4_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int MAT_DIM     = 4;
    localparam int MAT_SIZE    = MAT_DIM * MAT_DIM;
    localparam int IDX_W       = $clog2(MAT_SIZE);
    localparam int EIDX_W      = IDX_W + 1;
    localparam int DIM_W       = $clog2(MAT_DIM);
    localparam int STEP_W      = IDX_W + DIM_W;
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int ACC_W       = PROD_W + 2;

    localparam logic [EIDX_W-1:0] START_INDEX  = EIDX_W'(2 * MAT_SIZE - 1);
    localparam logic [IDX_W-1:0]  LAST_PRODUCT = IDX_W'(MAT_SIZE - 1);
    localparam logic [STEP_W-1:0] LAST_STEP    = {STEP_W{1'b1}};
    localparam logic [DIM_W-1:0]  FIRST_TERM   = '0;
    localparam logic [DIM_W-1:0]  LAST_TERM    = {DIM_W{1'b1}};

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = ~VAL_MAX;
    localparam logic signed [ACC_W-1:0]       ACC_MAX = ACC_W'(VAL_MAX);
    localparam logic signed [ACC_W-1:0]       ACC_MIN = ACC_W'(VAL_MIN);

    typedef struct packed {
        logic signed [DATA_W-1:0] element_value;
        logic [EIDX_W-1:0]        element_index;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] product_value;
        logic [IDX_W-1:0]         product_index;
        logic                     saturated;
        logic                     last;
    } t_out_item;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             done;
        logic [IDX_W-1:0] idx;
    } t_mac_ctl;

    typedef struct packed {
        logic                          valid;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          sat;
        logic [IDX_W-1:0]              idx;
    } t_mac_res;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_seq_state;

endpackage

>>> hdl/mm4_store.sv
// Operand memories for the left and right matrices, registered reads.
module mm4_store
    import mm4_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [EIDX_W-1:0]             i_wr_idx,
    input  logic signed [VALUE_WIDTH-1:0] i_wr_data,
    input  logic                          i_rd_en,
    input  logic [IDX_W-1:0]              i_rd_addr_a,
    input  logic [IDX_W-1:0]              i_rd_addr_b,
    output logic signed [VALUE_WIDTH-1:0] o_rd_a,
    output logic signed [VALUE_WIDTH-1:0] o_rd_b
);

    logic signed [VALUE_WIDTH-1:0] r_left  [MAT_SIZE];
    logic signed [VALUE_WIDTH-1:0] r_right [MAT_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (i_wr_idx[EIDX_W-1]) begin
                r_right[i_wr_idx[IDX_W-1:0]] <= i_wr_data;
            end else begin
                r_left[i_wr_idx[IDX_W-1:0]] <= i_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_a <= r_left[i_rd_addr_a];
            o_rd_b <= r_right[i_rd_addr_b];
        end
    end

endmodule

>>> hdl/mm4_mac.sv
// Shared multiply-accumulate unit with shift and saturation.
module mm4_mac
    import mm4_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  t_mac_ctl                      i_ctl,
    input  logic signed [VALUE_WIDTH-1:0] i_a,
    input  logic signed [VALUE_WIDTH-1:0] i_b,
    output t_mac_res                      o_res,
    output logic                          o_busy
);

    t_mac_ctl                 r_c1;
    t_mac_ctl                 r_c2;
    t_mac_ctl                 r_c3;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_shift;
    logic                     w_hi;
    logic                     w_lo;

    assign w_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else if (i_en) begin
            r_c1 <= i_ctl;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_prod;
            if (r_c2.valid) begin
                if (r_c2.first) begin
                    r_acc <= ACC_W'(r_prod);
                end else begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
        end
    end

    assign w_shift = r_acc >>> FRAC_BITS;
    assign w_hi    = w_shift > ACC_MAX;
    assign w_lo    = w_shift < ACC_MIN;

    always_comb begin
        o_res.valid = r_c3.valid && r_c3.done;
        o_res.idx   = r_c3.idx;
        o_res.sat   = w_hi || w_lo;
        if (w_hi) begin
            o_res.value = VAL_MAX;
        end else if (w_lo) begin
            o_res.value = VAL_MIN;
        end else begin
            o_res.value = w_shift[VALUE_WIDTH-1:0];
        end
    end

    assign o_busy = r_c1.valid || r_c2.valid || r_c3.valid;

endmodule

>>> hdl/matrix_multiply_4x4_top.sv
// Each element transfer is written to an operand store; index 31 starts a compute whose
// results, four products each, pass the store read, product, accumulator and output
// registers, the 16th flagged last. Throughput: one load per cycle unless stalled; a
// compute stalls input until its 64 multiply-accumulates on the single multiplier end.
// Output stall freezes the whole compute pipeline.
// Reset (synchronous, active low) clears control state; matrix stores are not cleared.
module matrix_multiply_4x4_top
    import mm4_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_seq_state                    r_state;
    t_seq_state                    n_state;
    logic [STEP_W-1:0]             r_step;
    logic [STEP_W-1:0]             n_step;
    logic                          r_out_valid;
    t_out_item                     r_out_item;
    logic                          w_adv;
    logic                          w_in_xfer;
    logic                          w_mac_busy;
    t_mac_ctl                      w_ctl;
    t_mac_res                      w_res;
    logic [IDX_W-1:0]              w_addr_a;
    logic [IDX_W-1:0]              w_addr_b;
    logic signed [VALUE_WIDTH-1:0] w_rd_a;
    logic signed [VALUE_WIDTH-1:0] w_rd_b;
    logic [DIM_W-1:0]              w_term;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == ST_RUN) || w_mac_busy;
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_term     = r_step[DIM_W-1:0];
    assign w_addr_a   = {w_term, r_step[IDX_W-1:DIM_W]};
    assign w_addr_b   = {r_step[STEP_W-1:IDX_W], w_term};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        w_ctl.valid = 1'b0;
        w_ctl.first = w_term == FIRST_TERM;
        w_ctl.done  = w_term == LAST_TERM;
        w_ctl.idx   = r_step[STEP_W-1:DIM_W];
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && i_in_item.element_index == START_INDEX) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                if (w_adv) begin
                    w_ctl.valid = 1'b1;
                    n_step      = r_step + STEP_W'(1);
                    if (r_step == LAST_STEP) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    mm4_store u_store (
        .i_clk       (i_clk),
        .i_wr_en     (w_in_xfer),
        .i_wr_idx    (i_in_item.element_index),
        .i_wr_data   (i_in_item.element_value[VALUE_WIDTH-1:0]),
        .i_rd_en     (w_adv),
        .i_rd_addr_a (w_addr_a),
        .i_rd_addr_b (w_addr_b),
        .o_rd_a      (w_rd_a),
        .o_rd_b      (w_rd_b)
    );

    mm4_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_ctl   (w_ctl),
        .i_a     (w_rd_a),
        .i_b     (w_rd_b),
        .o_res   (w_res),
        .o_busy  (w_mac_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.valid) begin
            r_out_item.product_value <= DATA_W'(w_res.value);
            r_out_item.product_index <= w_res.idx;
            r_out_item.saturated     <= w_res.sat;
            r_out_item.last          <= w_res.idx == LAST_PRODUCT;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hdl/mm4_checker.sv
// Port-level checks for the matrix multiplier, bound to the top level.
module mm4_checker
    import mm4_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    logic w_in_xfer;
    logic w_out_xfer;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = o_out_valid && !i_out_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled output transfer changed");

    a_start_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in_item.element_index == START_INDEX) |=> o_in_stall)
        else $error("input not stalled after compute start");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in_item.element_index != START_INDEX && !o_out_valid)
            |=> !o_out_valid)
        else $error("result appeared after a plain load");

    // the next result is either already presented or still in the pipeline
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && !o_out_item.last) |=> (o_in_stall || o_out_valid))
        else $error("results lost before the last one");

endmodule

bind matrix_multiply_4x4_top mm4_checker u_mm4_checker (.*);
